### sv/cdq_pkg.sv
// cdq_pkg: shared widths, command codes, status codes, controller states and
// the command/status structs between the deque controller and its datapath.
// No dependencies.
package cdq_pkg;

	localparam int DEPTH_DEF = 32;
	localparam int FUNC_W    = 3;
	localparam int DATA_W    = 32;
	localparam int SLOT_W    = 6;
	localparam int STAT_W    = 3;

	localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd0;
	localparam logic [FUNC_W-1:0] FN_PUSH_REAR  = 3'd1;
	localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 3'd2;
	localparam logic [FUNC_W-1:0] FN_POP_REAR   = 3'd3;
	localparam logic [FUNC_W-1:0] FN_OVERWRITE  = 3'd4;
	localparam logic [FUNC_W-1:0] FN_DUMP       = 3'd5;

	typedef enum logic [STAT_W-1:0] {
		ST_OK     = 3'd0,
		ST_OVER   = 3'd1,
		ST_UNDER  = 3'd2,
		ST_BADIDX = 3'd3,
		ST_EMPTY  = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_POP_OUT,
		S_DUMP_RD,
		S_DUMP_OUT
	} state_t;

	typedef enum logic [2:0] {
		PO_NONE,
		PO_PUSH_FRONT,
		PO_PUSH_REAR,
		PO_POP_FRONT,
		PO_POP_REAR
	} ptr_op_t;

	typedef struct packed {
		logic    load;      // capture the incoming command word
		ptr_op_t ptr_op;    // pointer update; push ops also pick the write address
		logic    mem_wr;    // store write (slot address when ptr_op is PO_NONE)
		logic    rd_pop;    // read at head or tail per ptr_op
		logic    rd_dump;   // read at dump pointer
		logic    dump_init;
		logic    dump_adv;
		logic    emit;      // load the output register
		logic    emit_rd;   // value from read data, else zero
		status_t emit_st;
		logic    emit_last;
	} dp_cmd_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic              full;
		logic              empty;
		logic              bad_idx;
		logic              dump_at_tail;
		logic              out_free;
	} dp_stat_t;

endpackage

### sv/cdq_ctrl.sv
// cdq_ctrl: command sequencer for the deque. Decodes the captured command
// and steps the datapath through writes, reads and dump traversal.
// Depends on cdq_pkg.
module cdq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  cdq_pkg::dp_stat_t st,
	output cdq_pkg::dp_cmd_t  cmd
);
	import cdq_pkg::*;

	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		cmd.ptr_op  = PO_NONE;
		cmd.emit_st = ST_OK;
		in_stall = (state_q != S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_nx = S_EXEC;
				end
			end
			S_EXEC: begin
				unique case (st.func)
					FN_PUSH_FRONT, FN_PUSH_REAR: begin
						if (st.out_free) begin
							cmd.emit      = 1'b1;
							cmd.emit_last = 1'b1;
							if (st.full) begin
								cmd.emit_st = ST_OVER;
							end else begin
								cmd.mem_wr = 1'b1;
								cmd.ptr_op = (st.func == FN_PUSH_FRONT) ? PO_PUSH_FRONT
								                                        : PO_PUSH_REAR;
							end
							state_nx = S_IDLE;
						end
					end
					FN_POP_FRONT, FN_POP_REAR: begin
						if (st.empty) begin
							if (st.out_free) begin
								cmd.emit      = 1'b1;
								cmd.emit_last = 1'b1;
								cmd.emit_st   = ST_UNDER;
								state_nx      = S_IDLE;
							end
						end else begin
							// read uses the pointers before this update
							cmd.rd_pop = 1'b1;
							cmd.ptr_op = (st.func == FN_POP_FRONT) ? PO_POP_FRONT
							                                       : PO_POP_REAR;
							state_nx   = S_POP_OUT;
						end
					end
					FN_OVERWRITE: begin
						if (st.out_free) begin
							cmd.emit      = 1'b1;
							cmd.emit_last = 1'b1;
							if (st.bad_idx) begin
								cmd.emit_st = ST_BADIDX;
							end else begin
								cmd.mem_wr = 1'b1;
							end
							state_nx = S_IDLE;
						end
					end
					FN_DUMP: begin
						if (st.empty) begin
							if (st.out_free) begin
								cmd.emit      = 1'b1;
								cmd.emit_last = 1'b1;
								cmd.emit_st   = ST_EMPTY;
								state_nx      = S_IDLE;
							end
						end else begin
							cmd.dump_init = 1'b1;
							state_nx      = S_DUMP_RD;
						end
					end
					default: begin
						state_nx = S_IDLE;
					end
				endcase
			end
			S_POP_OUT: begin
				if (st.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_rd   = 1'b1;
					cmd.emit_last = 1'b1;
					state_nx      = S_IDLE;
				end
			end
			S_DUMP_RD: begin
				cmd.rd_dump = 1'b1;
				state_nx    = S_DUMP_OUT;
			end
			S_DUMP_OUT: begin
				if (st.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_rd   = 1'b1;
					cmd.emit_last = st.dump_at_tail;
					if (st.dump_at_tail) begin
						state_nx = S_IDLE;
					end else begin
						cmd.dump_adv = 1'b1;
						state_nx     = S_DUMP_RD;
					end
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

endmodule

### sv/cdq_dp.sv
// cdq_dp: deque datapath: command word register, store with registered
// read, head/tail pointers, empty flag, dump pointer and output register.
// Depends on cdq_pkg.
module cdq_dp #(
	parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cdq_pkg::dp_cmd_t           cmd,
	output cdq_pkg::dp_stat_t          st,
	input  logic [cdq_pkg::FUNC_W-1:0] func,
	input  logic [cdq_pkg::DATA_W-1:0] value_in,
	input  logic [cdq_pkg::SLOT_W-1:0] slot,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [cdq_pkg::DATA_W-1:0] value_out,
	output logic [cdq_pkg::STAT_W-1:0] status,
	output logic                       last
);
	import cdq_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam logic [PTR_W-1:0]  LAST_IDX = PTR_W'(DEPTH - 1);
	localparam logic [SLOT_W:0]   DEPTH_X  = (SLOT_W + 1)'(DEPTH);

	logic [FUNC_W-1:0] func_q;
	logic [DATA_W-1:0] value_q;
	logic [SLOT_W-1:0] slot_q;

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rd_q;

	logic [PTR_W-1:0] head_q, tail_q, dump_q;
	logic             empty_q;

	logic             out_valid_q, last_q;
	logic [DATA_W-1:0] value_out_q;
	logic [STAT_W-1:0] status_q;

	logic [PTR_W-1:0] head_prev, head_next, tail_prev, tail_next, dump_next;
	logic [PTR_W-1:0] wr_addr, rd_addr;
	logic             rd_en, out_free;

	assign head_prev = (head_q == '0) ? LAST_IDX : head_q - 1'b1;
	assign head_next = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
	assign tail_prev = (tail_q == '0) ? LAST_IDX : tail_q - 1'b1;
	assign tail_next = (tail_q == LAST_IDX) ? '0 : tail_q + 1'b1;
	assign dump_next = (dump_q == LAST_IDX) ? '0 : dump_q + 1'b1;

	assign out_free = !out_valid_q || !out_stall;

	assign st.func         = func_q;
	assign st.full         = !empty_q && (tail_next == head_q);
	assign st.empty        = empty_q;
	assign st.bad_idx      = ({1'b0, slot_q} >= DEPTH_X);
	assign st.dump_at_tail = (dump_q == tail_q);
	assign st.out_free     = out_free;

	always_comb begin
		unique case (cmd.ptr_op)
			PO_PUSH_FRONT: wr_addr = empty_q ? '0 : head_prev;
			PO_PUSH_REAR:  wr_addr = empty_q ? '0 : tail_next;
			default:       wr_addr = slot_q[PTR_W-1:0];
		endcase
	end

	assign rd_en   = cmd.rd_pop || cmd.rd_dump;
	assign rd_addr = cmd.rd_dump ? dump_q
	               : (cmd.ptr_op == PO_POP_FRONT) ? head_q : tail_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q  <= func;
			value_q <= value_in;
			slot_q  <= slot;
		end
		if (cmd.mem_wr) begin
			mem_q[wr_addr] <= value_q;
		end
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
		if (cmd.dump_init) begin
			dump_q <= head_q;
		end else if (cmd.dump_adv) begin
			dump_q <= dump_next;
		end
		if (cmd.emit) begin
			value_out_q <= cmd.emit_rd ? rd_q : '0;
			status_q    <= cmd.emit_st;
			last_q      <= cmd.emit_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			empty_q <= 1'b1;
		end else begin
			unique case (cmd.ptr_op)
				PO_PUSH_FRONT, PO_PUSH_REAR: begin
					if (empty_q) begin
						head_q  <= '0;
						tail_q  <= '0;
						empty_q <= 1'b0;
					end else if (cmd.ptr_op == PO_PUSH_FRONT) begin
						head_q <= head_prev;
					end else begin
						tail_q <= tail_next;
					end
				end
				PO_POP_FRONT, PO_POP_REAR: begin
					// popping the only word empties the deque and homes both pointers
					if (head_q == tail_q) begin
						head_q  <= '0;
						tail_q  <= '0;
						empty_q <= 1'b1;
					end else if (cmd.ptr_op == PO_POP_FRONT) begin
						head_q <= head_next;
					end else begin
						tail_q <= tail_prev;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign value_out = value_out_q;
	assign status    = status_q;
	assign last      = last_q;

endmodule

### sv/circular_deque_core.sv
// circular_deque_core: top level of the circular-buffer deque.
// Instantiates cdq_ctrl (sequencer) and cdq_dp (store, pointers, output reg).
// Depends on cdq_pkg, cdq_ctrl and cdq_dp.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+--------------------------
//  in      | input     | in_valid / in_stall | func, value_in, slot
//  out     | output    | out_valid/out_stall | value_out, status, last
//
// One command at a time. Push and overwrite are accepted, then executed;
// a pop is accepted, reads the store, then loads the output. A dump is
// accepted, then per held word does one store read and one output load.
// Reset clears pointers, the empty flag, the sequencer and out_valid; the
// store is not cleared. A stalled output word holds and delays the sequencer;
// the next command is taken once the current one has loaded its final word.
module circular_deque_core #(
	parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [cdq_pkg::FUNC_W-1:0] func,
	input  logic [cdq_pkg::DATA_W-1:0] value_in,
	input  logic [cdq_pkg::SLOT_W-1:0] slot,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [cdq_pkg::DATA_W-1:0] value_out,
	output logic [cdq_pkg::STAT_W-1:0] status,
	output logic                       last
);
	import cdq_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t st;

	cdq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	cdq_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.func      (func),
		.value_in  (value_in),
		.slot      (slot),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.value_out (value_out),
		.status    (status),
		.last      (last)
	);

endmodule
